[hw/rtl/periodic_task_tick_table_unit_assert.svh]
// assertion macros for the periodic task tick table
// each check samples on clk and is disabled while arst_n is low
`ifndef PERIODIC_TASK_TICK_TABLE_UNIT_ASSERT_SVH
`define PERIODIC_TASK_TICK_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// condition holds at every edge
`define PTT_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);
// consequent holds in the same cycle as the antecedent
`define PTT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// consequent holds in the cycle after the antecedent
`define PTT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PTT_ASSERT_ALWAYS(label, cond, msg)
`define PTT_ASSERT_SAME(label, ante, cons, msg)
`define PTT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[hw/rtl/ptt_pkg.sv]
package ptt_pkg;

	// field widths
	localparam int OP_W     = 3;
	localparam int PERIOD_W = 16;
	localparam int ID_W     = 4;
	localparam int KIND_W   = 2;
	localparam int SLOT_W   = 4;

	// table size and result limit per run command
	localparam int TASK_SLOTS_DEF = 16;
	localparam int MAX_RESULTS    = 16;
	localparam int FOUND_W        = $clog2(MAX_RESULTS);

	// command codes
	typedef enum logic [OP_W-1:0] {
		OP_ADD     = 3'd0,
		OP_TICK    = 3'd1,
		OP_RUN     = 3'd2,
		OP_ENABLE  = 3'd3,
		OP_DISABLE = 3'd4
	} op_t;

	// reply codes
	typedef enum logic [KIND_W-1:0] {
		KIND_GRANTED = 2'd0,
		KIND_FULL    = 2'd1,
		KIND_DUE     = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	// controller to datapath
	typedef struct packed {
		logic accept;   // take the request word
		logic step;     // evaluate one slot and issue the next read
		logic finish;   // load the closing reply word
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_stall;  // a due reply is waiting on the reply register
		logic scan_stop;   // the slot being evaluated ends the scan
		logic scan_end;    // all slots read and evaluated
		logic out_free;    // reply register can take a word this cycle
		logic word_due;    // the command closes with a reply word
	} dp_stat_t;

endpackage

[hw/rtl/periodic_task_tick_table_unit.sv]
// periodic task tick table: a table of TASK_SLOTS periodic task slots driven by commands
// request channel (req_valid/req_stall) carries one command word: op, period, task_id
// reply channel (rsp_valid/rsp_stall) carries reply words: reply_kind, slot, last
// add claims the lowest free slot and replies granted or full; tick counts down every
// active enabled slot; run replies once per due slot in index order (at most 16, the
// last one flagged) or once with nothing due; enable and disable give no reply
// enable, disable and unknown codes do not walk the table and the block is ready again at once
// add, tick and run walk the slots one per cycle, save where run pauses for a stalled
// reply, through the period and count memories; add stops at the free slot it finds,
// and the block takes the next command once the walk has ended and its closing reply
// word, if any, is loaded, which waits while the reply register is stalled
// the first reply word is registered: its slot passes the evaluation stage and the holding
// register before the reply register; a word of run waits in the holding register until
// the next due slot is found, so reply words flow at up to one per slot read
// a stalled reply holds its word; run pauses its walk while a further due word waits
// on it, other commands are still taken while a finished reply waits
// reset clears the active and enable bits of all slots and empties the reply register;
// periods and counts are written by add before they are read
`include "periodic_task_tick_table_unit_assert.svh"

module periodic_task_tick_table_unit #(
	parameter int TASK_SLOTS = ptt_pkg::TASK_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [ptt_pkg::OP_W-1:0]       op,
	input  logic [ptt_pkg::PERIOD_W-1:0]   period,
	input  logic [ptt_pkg::ID_W-1:0]       task_id,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [ptt_pkg::KIND_W-1:0]     reply_kind,
	output logic [ptt_pkg::SLOT_W-1:0]     slot,
	output logic                           last
);

	ptt_pkg::ctl_cmd_t ctl;
	ptt_pkg::dp_stat_t stat;

	// sequencer
	ptt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.op        (op),
		.stat      (stat),
		.req_stall (req_stall),
		.ctl       (ctl)
	);

	// slot table, scan stage and reply register
	ptt_dpath #(
		.TASK_SLOTS (TASK_SLOTS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.op         (op),
		.period     (period),
		.task_id    (task_id),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.reply_kind (reply_kind),
		.slot       (slot),
		.last       (last)
	);

	// checks
	`PTT_ASSERT_ALWAYS(a_cmd_exclusive, $onehot0({ctl.accept, ctl.step, ctl.finish}),
		"controller commands overlap")
	`PTT_ASSERT_SAME(a_finish_room, ctl.finish, (!rsp_valid || !rsp_stall),
		"closing word loaded over a stalled reply")
	`PTT_ASSERT_NEXT(a_scan_busy, req_valid && !req_stall && (op == ptt_pkg::OP_ADD ||
		op == ptt_pkg::OP_TICK || op == ptt_pkg::OP_RUN), req_stall,
		"table walk did not start")

endmodule

[hw/rtl/ptt_ctrl.sv]
module ptt_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	input  logic [ptt_pkg::OP_W-1:0]       op,
	input  ptt_pkg::dp_stat_t              stat,
	output logic                           req_stall,
	output ptt_pkg::ctl_cmd_t              ctl
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   scan_op;

	// commands that walk the slot table
	always_comb begin
		case (ptt_pkg::op_t'(op)) inside
			ptt_pkg::OP_ADD, ptt_pkg::OP_TICK, ptt_pkg::OP_RUN: scan_op = 1'b1;
			default: scan_op = 1'b0;
		endcase
	end

	// command decode
	always_comb begin
		ctl.accept = (state_q == ST_IDLE) && req_valid;
		ctl.step   = (state_q == ST_SCAN) && !stat.scan_stall;
		ctl.finish = (state_q == ST_FINISH) && stat.word_due && stat.out_free;
	end

	assign req_stall = (state_q != ST_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid && scan_op) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (ctl.step && (stat.scan_stop || stat.scan_end)) state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!stat.word_due || stat.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/ptt_dpath.sv]
module ptt_dpath #(
	parameter int TASK_SLOTS = ptt_pkg::TASK_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ptt_pkg::ctl_cmd_t              ctl,
	output ptt_pkg::dp_stat_t              stat,
	input  logic [ptt_pkg::OP_W-1:0]       op,
	input  logic [ptt_pkg::PERIOD_W-1:0]   period,
	input  logic [ptt_pkg::ID_W-1:0]       task_id,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [ptt_pkg::KIND_W-1:0]     reply_kind,
	output logic [ptt_pkg::SLOT_W-1:0]     slot,
	output logic                           last
);

	localparam int IDX_W    = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int PERIOD_W = ptt_pkg::PERIOD_W;
	localparam int SLOT_W   = ptt_pkg::SLOT_W;
	localparam int FOUND_W  = ptt_pkg::FOUND_W;

	// slot flags, cleared at reset
	logic [TASK_SLOTS-1:0] active_q;
	logic [TASK_SLOTS-1:0] enabled_q;

	// period and remaining count memories
	logic [PERIOD_W-1:0] per_mem [TASK_SLOTS];
	logic [PERIOD_W-1:0] rem_mem [TASK_SLOTS];

	// latched command
	ptt_pkg::op_t        op_q;
	logic [PERIOD_W-1:0] period_q;

	// scan read pointer and evaluation stage
	logic [IDX_W-1:0]    rd_idx_q;
	logic                rd_busy_q;
	logic                ev_valid_s1;
	logic [IDX_W-1:0]    ev_idx_s1;
	logic [PERIOD_W-1:0] per_s1;
	logic [PERIOD_W-1:0] rem_s1;

	// held reply slot and due count
	logic                pend_valid_q;
	logic [IDX_W-1:0]    pend_slot_q;
	logic [FOUND_W-1:0]  found_q;

	// reply register
	logic                  rsp_valid_q;
	ptt_pkg::kind_t        rsp_kind_q;
	logic [SLOT_W-1:0]     rsp_slot_q;
	logic                  rsp_last_q;

	logic                hit;
	logic                live;
	logic                commit;
	logic                push_mid;
	logic                push_word;
	logic                rd_en;
	logic                rd_last;
	logic                id_ok;
	logic [IDX_W-1:0]    id_idx;
	logic [PERIOD_W-1:0] rem_wdata;
	ptt_pkg::kind_t      fin_kind;

	// slot condition for the current command
	always_comb begin
		case (op_q)
			ptt_pkg::OP_ADD:  hit = !active_q[ev_idx_s1];
			ptt_pkg::OP_TICK: hit = active_q[ev_idx_s1] && enabled_q[ev_idx_s1];
			ptt_pkg::OP_RUN:  hit = active_q[ev_idx_s1] && enabled_q[ev_idx_s1] &&
				(rem_s1 == '0);
			default:          hit = 1'b0;
		endcase
	end

	assign live     = ev_valid_s1 && hit;
	assign commit   = ctl.step && live;
	assign push_mid = live && (op_q == ptt_pkg::OP_RUN) && pend_valid_q;
	assign rd_en    = ctl.step && rd_busy_q;
	assign rd_last  = (rd_idx_q == IDX_W'(TASK_SLOTS - 1));

	// status to controller
	always_comb begin
		stat.out_free   = !rsp_valid_q || !rsp_stall;
		stat.scan_stall = push_mid && !stat.out_free;
		stat.scan_stop  = live && ((op_q == ptt_pkg::OP_ADD) ||
			((op_q == ptt_pkg::OP_RUN) && (found_q == FOUND_W'(ptt_pkg::MAX_RESULTS - 1))));
		stat.scan_end   = !ev_valid_s1 && !rd_busy_q;
		stat.word_due   = (op_q != ptt_pkg::OP_TICK);
	end

	// new remaining count for the evaluated slot
	always_comb begin
		case (op_q)
			ptt_pkg::OP_ADD:  rem_wdata = period_q;
			ptt_pkg::OP_TICK: rem_wdata = rem_s1 - 1'b1;
			ptt_pkg::OP_RUN:  rem_wdata = per_s1;
			default:          rem_wdata = rem_s1;
		endcase
	end

	// memories: write the evaluated slot, read the next one
	always_ff @(posedge clk) begin
		if (commit && (op_q == ptt_pkg::OP_ADD)) per_mem[ev_idx_s1] <= period_q;
		if (rd_en) per_s1 <= per_mem[rd_idx_q];
	end

	always_ff @(posedge clk) begin
		if (commit) rem_mem[ev_idx_s1] <= rem_wdata;
		if (rd_en) rem_s1 <= rem_mem[rd_idx_q];
	end

	// enable and disable target
	assign id_ok  = (32'(task_id) < 32'(TASK_SLOTS));
	assign id_idx = IDX_W'(task_id);

	// slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			enabled_q <= '0;
		end else begin
			if (ctl.accept && id_ok && (op == ptt_pkg::OP_ENABLE)) enabled_q[id_idx] <= 1'b1;
			if (ctl.accept && id_ok && (op == ptt_pkg::OP_DISABLE)) enabled_q[id_idx] <= 1'b0;
			if (commit && (op_q == ptt_pkg::OP_ADD)) begin
				active_q[ev_idx_s1]  <= 1'b1;
				enabled_q[ev_idx_s1] <= 1'b1;
			end
		end
	end

	// command latch and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q         <= ptt_pkg::OP_TICK;
			period_q     <= '0;
			rd_idx_q     <= '0;
			rd_busy_q    <= 1'b0;
			ev_valid_s1  <= 1'b0;
			pend_valid_q <= 1'b0;
			found_q      <= '0;
		end else if (ctl.accept) begin
			op_q         <= ptt_pkg::op_t'(op);
			period_q     <= period;
			rd_idx_q     <= '0;
			rd_busy_q    <= 1'b1;
			ev_valid_s1  <= 1'b0;
			pend_valid_q <= 1'b0;
			found_q      <= '0;
		end else if (ctl.step) begin
			ev_valid_s1 <= rd_busy_q;
			if (rd_busy_q) begin
				if (rd_last) begin
					rd_busy_q <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end
			if (live && (op_q != ptt_pkg::OP_TICK)) pend_valid_q <= 1'b1;
			if (live && (op_q == ptt_pkg::OP_RUN)) found_q <= found_q + 1'b1;
		end
	end

	// slot index of the evaluation stage and the held reply
	always_ff @(posedge clk) begin
		if (rd_en) ev_idx_s1 <= rd_idx_q;
		if (commit && (op_q != ptt_pkg::OP_TICK)) pend_slot_q <= ev_idx_s1;
	end

	// closing reply word
	always_comb begin
		if (op_q == ptt_pkg::OP_ADD) begin
			fin_kind = pend_valid_q ? ptt_pkg::KIND_GRANTED : ptt_pkg::KIND_FULL;
		end else begin
			fin_kind = pend_valid_q ? ptt_pkg::KIND_DUE : ptt_pkg::KIND_NONE;
		end
	end

	assign push_word = (commit && push_mid) || ctl.finish;

	// reply register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (push_word) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// reply register payload
	always_ff @(posedge clk) begin
		if (commit && push_mid) begin
			rsp_kind_q <= ptt_pkg::KIND_DUE;
			rsp_slot_q <= SLOT_W'(pend_slot_q);
			rsp_last_q <= 1'b0;
		end else if (ctl.finish) begin
			rsp_kind_q <= fin_kind;
			rsp_slot_q <= pend_valid_q ? SLOT_W'(pend_slot_q) : '0;
			rsp_last_q <= 1'b1;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign reply_kind = rsp_kind_q;
	assign slot       = rsp_slot_q;
	assign last       = rsp_last_q;

endmodule

[bench/tb_periodic_task_tick_table_unit.sv]
module tb_periodic_task_tick_table_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS        = ptt_pkg::TASK_SLOTS_DEF;
	localparam int RANDOM_WORDS = 154;
	localparam int QUIET_FROM   = 125;
	localparam int PRESSURE_AT  = 45;
	localparam int HOLD_CYCLES  = 250;
	localparam int DRAIN_CYCLES = 2 * SLOTS + 10;
	localparam int MAX_SHOWN    = 10;

	// op codes the block ignores
	localparam logic [ptt_pkg::OP_W-1:0] OP_UNUSED_LO  = 3'd5;
	localparam logic [ptt_pkg::OP_W-1:0] OP_UNUSED_MID = 3'd6;
	localparam logic [ptt_pkg::OP_W-1:0] OP_UNUSED_HI  = 3'd7;

	typedef struct packed {
		ptt_pkg::kind_t             kind;
		logic [ptt_pkg::SLOT_W-1:0] slot;
		logic                       last;
	} reply_t;

	typedef struct packed {
		logic [ptt_pkg::OP_W-1:0]     cmd;
		logic [ptt_pkg::PERIOD_W-1:0] per;
		logic [ptt_pkg::ID_W-1:0]     id;
		bit                           typed;
		reply_t                       rep;
	} row_t;

	localparam reply_t NO_REPLY = '{ptt_pkg::KIND_NONE, 4'd0, 1'b0};

	// directed commands, with the reply typed in where it is obvious
	localparam int DIRECTED_ROWS = 26;
	localparam row_t DIRECTED [DIRECTED_ROWS] = '{
		'{ptt_pkg::OP_RUN,     16'h0000, 4'd0,  1'b1, '{ptt_pkg::KIND_NONE,    4'd0, 1'b1}},
		'{ptt_pkg::OP_TICK,    16'h0000, 4'd0,  1'b0, NO_REPLY},
		'{ptt_pkg::OP_ENABLE,  16'h0000, 4'd15, 1'b0, NO_REPLY},
		'{ptt_pkg::OP_DISABLE, 16'hffff, 4'd0,  1'b0, NO_REPLY},
		'{OP_UNUSED_LO,        16'hffff, 4'd15, 1'b0, NO_REPLY},
		'{OP_UNUSED_HI,        16'h0000, 4'd0,  1'b0, NO_REPLY},
		'{OP_UNUSED_MID,       16'h5a5a, 4'd10, 1'b0, NO_REPLY},
		'{ptt_pkg::OP_ADD,     16'h0000, 4'd0,  1'b1, '{ptt_pkg::KIND_GRANTED, 4'd0, 1'b1}},
		'{ptt_pkg::OP_RUN,     16'h0000, 4'd0,  1'b0, NO_REPLY},
		'{ptt_pkg::OP_RUN,     16'hffff, 4'd15, 1'b0, NO_REPLY},
		'{ptt_pkg::OP_ADD,     16'hffff, 4'd0,  1'b1, '{ptt_pkg::KIND_GRANTED, 4'd1, 1'b1}},
		'{ptt_pkg::OP_ADD,     16'h0001, 4'd15, 1'b1, '{ptt_pkg::KIND_GRANTED, 4'd2, 1'b1}},
		'{ptt_pkg::OP_ADD,     16'h0002, 4'd0,  1'b1, '{ptt_pkg::KIND_GRANTED, 4'd3, 1'b1}},
		'{ptt_pkg::OP_DISABLE, 16'h0000, 4'd0,  1'b0, NO_REPLY},
		'{ptt_pkg::OP_TICK,    16'hffff, 4'd15, 1'b0, NO_REPLY},
		'{ptt_pkg::OP_RUN,     16'h0000, 4'd0,  1'b0, NO_REPLY},
		'{ptt_pkg::OP_ENABLE,  16'h0000, 4'd0,  1'b0, NO_REPLY},
		'{ptt_pkg::OP_RUN,     16'h0000, 4'd0,  1'b0, NO_REPLY},
		'{ptt_pkg::OP_TICK,    16'h0000, 4'd0,  1'b0, NO_REPLY},
		'{ptt_pkg::OP_RUN,     16'h0000, 4'd0,  1'b0, NO_REPLY},
		'{ptt_pkg::OP_TICK,    16'h0000, 4'd0,  1'b0, NO_REPLY},
		'{ptt_pkg::OP_RUN,     16'h0000, 4'd0,  1'b0, NO_REPLY},
		'{ptt_pkg::OP_DISABLE, 16'h0000, 4'd15, 1'b0, NO_REPLY},
		'{ptt_pkg::OP_ENABLE,  16'h0000, 4'd15, 1'b0, NO_REPLY},
		'{ptt_pkg::OP_ADD,     16'h8000, 4'd0,  1'b1, '{ptt_pkg::KIND_GRANTED, 4'd4, 1'b1}},
		'{ptt_pkg::OP_RUN,     16'h0000, 4'd0,  1'b0, NO_REPLY}
	};

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         req_valid  = 1'b0;
	logic                         req_stall;
	logic [ptt_pkg::OP_W-1:0]     op         = '0;
	logic [ptt_pkg::PERIOD_W-1:0] period     = '0;
	logic [ptt_pkg::ID_W-1:0]     task_id    = '0;
	logic                         rsp_valid;
	logic                         rsp_stall  = 1'b0;
	logic [ptt_pkg::KIND_W-1:0]   reply_kind;
	logic [ptt_pkg::SLOT_W-1:0]   slot;
	logic                         last;

	// shadow copy of the slot table
	bit                           tbl_active  [SLOTS];
	bit                           tbl_enabled [SLOTS];
	logic [ptt_pkg::PERIOD_W-1:0] tbl_period  [SLOTS];
	logic [ptt_pkg::PERIOD_W-1:0] tbl_count   [SLOTS];

	reply_t pending_replies [$];
	reply_t exp_reply;

	int  words_sent    = 0;
	int  replies_seen  = 0;
	int  due_seen      = 0;
	int  full_seen     = 0;
	int  none_seen     = 0;
	int  errors        = 0;
	bit  quiet         = 1'b0;
	int  hold_left     = 0;
	int  burst_left    = 0;
	bit  hold_done     = 1'b0;

	periodic_task_tick_table_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.op         (op),
		.period     (period),
		.task_id    (task_id),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.reply_kind (reply_kind),
		.slot       (slot),
		.last       (last)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

	// update the shadow table for one command and queue the replies it causes
	task automatic apply_command(input logic [ptt_pkg::OP_W-1:0] cmd,
			input logic [ptt_pkg::PERIOD_W-1:0] per,
			input logic [ptt_pkg::ID_W-1:0] id, input bit record);
		reply_t found [$];
		bit     granted;
		granted = 1'b0;
		case (cmd)
			ptt_pkg::OP_ADD: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!granted && !tbl_active[i]) begin
						granted        = 1'b1;
						tbl_active[i]  = 1'b1;
						tbl_enabled[i] = 1'b1;
						tbl_period[i]  = per;
						tbl_count[i]   = per;
						found.push_back('{ptt_pkg::KIND_GRANTED, i[ptt_pkg::SLOT_W-1:0], 1'b1});
					end
				end
				if (!granted)
					found.push_back('{ptt_pkg::KIND_FULL, 4'd0, 1'b1});
			end
			ptt_pkg::OP_TICK: begin
				for (int i = 0; i < SLOTS; i++)
					if (tbl_active[i] && tbl_enabled[i])
						tbl_count[i] = tbl_count[i] - 1'b1;
			end
			ptt_pkg::OP_RUN: begin
				for (int i = 0; i < SLOTS && found.size() < ptt_pkg::MAX_RESULTS; i++) begin
					if (tbl_active[i] && tbl_enabled[i] && tbl_count[i] == '0) begin
						tbl_count[i] = tbl_period[i];
						found.push_back('{ptt_pkg::KIND_DUE, i[ptt_pkg::SLOT_W-1:0], 1'b0});
					end
				end
				if (found.size() == 0)
					found.push_back('{ptt_pkg::KIND_NONE, 4'd0, 1'b1});
				else
					found[found.size()-1].last = 1'b1;
			end
			ptt_pkg::OP_ENABLE: begin
				if (int'(id) < SLOTS)
					tbl_enabled[id] = 1'b1;
			end
			ptt_pkg::OP_DISABLE: begin
				if (int'(id) < SLOTS)
					tbl_enabled[id] = 1'b0;
			end
			default: ;
		endcase
		if (record)
			foreach (found[k])
				pending_replies.push_back(found[k]);
	endtask

	// offer one command word and wait until the block takes it
	task automatic offer_word(input logic [ptt_pkg::OP_W-1:0] cmd,
			input logic [ptt_pkg::PERIOD_W-1:0] per,
			input logic [ptt_pkg::ID_W-1:0] id, input bit typed, input reply_t typed_rep);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req_valid <= 1'b1;
		op        <= cmd;
		period    <= per;
		task_id   <= id;
		do @(posedge clk); while (req_stall);
		words_sent++;
		apply_command(cmd, per, id, !typed);
		if (typed)
			pending_replies.push_back(typed_rep);
	endtask

	// random command mix, mostly small periods so slots come due often
	task automatic random_word();
		logic [ptt_pkg::OP_W-1:0]     cmd;
		logic [ptt_pkg::PERIOD_W-1:0] per;
		int                           pick;
		int                           pick_per;
		pick     = $urandom_range(0, 99);
		per      = ptt_pkg::PERIOD_W'($urandom);
		pick_per = $urandom_range(0, 19);
		if (pick < 12) begin
			cmd = ptt_pkg::OP_ADD;
			if (pick_per == 0)
				per = '0;
			else if (pick_per < 16)
				per = ptt_pkg::PERIOD_W'($urandom_range(1, 6));
		end else if (pick < 45)
			cmd = ptt_pkg::OP_TICK;
		else if (pick < 75)
			cmd = ptt_pkg::OP_RUN;
		else if (pick < 85)
			cmd = ptt_pkg::OP_ENABLE;
		else if (pick < 95)
			cmd = ptt_pkg::OP_DISABLE;
		else
			cmd = OP_UNUSED_LO + ptt_pkg::OP_W'($urandom_range(0, 2));
		offer_word(cmd, per, ptt_pkg::ID_W'($urandom_range(0, 15)), 1'b0, NO_REPLY);
	endtask

	// reply stall: random bursts, one long hold-off, none at the end
	always @(posedge clk) begin
		if (!hold_done && words_sent >= PRESSURE_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (quiet) begin
			rsp_stall <= 1'b0;
		end else if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 7);
			rsp_stall <= ($urandom_range(0, 2) == 0);
		end
	end

	task automatic note_mismatch(input string what);
		errors++;
		if (errors <= MAX_SHOWN)
			$display("mismatch: %s", what);
	endtask

	// compare each accepted reply word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			replies_seen++;
			if (pending_replies.size() == 0) begin
				note_mismatch($sformatf("unexpected reply kind %0d slot %0d last %0d",
					reply_kind, slot, last));
			end else begin
				exp_reply = pending_replies.pop_front();
				if (reply_kind !== exp_reply.kind || slot !== exp_reply.slot ||
						last !== exp_reply.last)
					note_mismatch($sformatf(
						"expected kind %0d slot %0d last %0d, got kind %0d slot %0d last %0d",
						exp_reply.kind, exp_reply.slot, exp_reply.last,
						reply_kind, slot, last));
				case (exp_reply.kind)
					ptt_pkg::KIND_DUE:  due_seen++;
					ptt_pkg::KIND_FULL: full_seen++;
					ptt_pkg::KIND_NONE: none_seen++;
					default: ;
				endcase
			end
		end
	end

	// reset, directed table, random commands, drain
	initial begin
		foreach (tbl_active[i]) begin
			tbl_active[i]  = 1'b0;
			tbl_enabled[i] = 1'b0;
			tbl_period[i]  = '0;
			tbl_count[i]   = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIRECTED_ROWS; r++)
			offer_word(DIRECTED[r].cmd, DIRECTED[r].per, DIRECTED[r].id,
				DIRECTED[r].typed, DIRECTED[r].rep);

		for (int r = 0; r < RANDOM_WORDS; r++) begin
			if (r == QUIET_FROM)
				quiet = 1'b1;
			random_word();
		end
		req_valid <= 1'b0;

		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d command words and %0d reply words", words_sent, replies_seen);
		$display("replies: %0d due, %0d nothing due, %0d table full, %0d mismatches",
			due_seen, none_seen, full_seen, errors);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_ctrl.sv
hw/rtl/ptt_dpath.sv
hw/rtl/periodic_task_tick_table_unit.sv
bench/tb_periodic_task_tick_table_unit.sv
